>>> rtl/graph_dfs_preorder_top_macros.svh
// Assertion macros shared by the depth-first walk RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef GRAPH_DFS_PREORDER_TOP_MACROS_SVH
`define GRAPH_DFS_PREORDER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gdp_pkg.sv
// Shared constants and controller/datapath interface types for the depth-first walk.
// No dependencies.
package gdp_pkg;

    localparam int VTX_W            = 6;
    localparam int VCOUNT_W         = 7;
    localparam int WEIGHT_W         = 32;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [WEIGHT_W-1:0] NO_EDGE_MARK = 32'h3f3f3f3f;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear_visited;
        logic start_walk;
        logic push;
        logic pop;
        logic emit_bad;
        logic flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic found;
        logic depth_is_one;
        logic out_free;
        logic bad_start;
    } t_status;

endpackage

>>> rtl/gdp_ram.sv
// Generic single-write, single-read RAM with per-bit write mask and registered read.
// No dependencies.
module gdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [WIDTH-1:0]         i_wmask,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < WIDTH; b++) begin
                if (i_wmask[b]) begin
                    r_mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gdp_ctrl.sv
// Controller state machine for the depth-first walk: input handshake and step sequencing.
// Depends on gdp_pkg and graph_dfs_preorder_top_macros.svh.
`include "graph_dfs_preorder_top_macros.svh"

module gdp_ctrl import gdp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BAD   = 7'b0000010,
        S_TOP   = 7'b0000100,
        S_ROW   = 7'b0001000,
        S_CAND  = 7'b0010000,
        S_PICK  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic in_take;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_operation == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_status.bad_start) begin
                        o_cmd.clear_visited = 1'b1;
                        n_state             = S_BAD;
                    end else begin
                        o_cmd.start_walk = 1'b1;
                        n_state          = S_TOP;
                    end
                end
            end
            S_BAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TOP:  n_state = S_ROW;
            S_ROW:  n_state = S_CAND;
            S_CAND: n_state = S_PICK;
            S_PICK: begin
                if (i_status.found) begin
                    if (i_status.out_free) begin
                        o_cmd.push = 1'b1;
                        n_state    = S_TOP;
                    end
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_status.depth_is_one ? S_FLUSH : S_TOP;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `GDP_ASSERT_NEXT(a_pick_waits, (r_state == S_PICK) && i_status.found && !i_status.out_free, r_state == S_PICK, "walk left pick while result was blocked")

endmodule

>>> rtl/gdp_datapath.sv
// Datapath for the depth-first walk: adjacency and stack memories, visited set,
// candidate search, pending and output registers. Depends on gdp_pkg, gdp_ram and the macros.
`include "graph_dfs_preorder_top_macros.svh"

module gdp_datapath import gdp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [VCOUNT_W-1:0] i_cfg_data,
    input  logic [VTX_W-1:0]    i_row_vertex,
    input  logic [VTX_W-1:0]    i_col_vertex,
    input  logic [WEIGHT_W-1:0] i_edge_weight,
    input  logic [VTX_W-1:0]    i_start_vertex,
    input  t_cmd                i_cmd,
    input  logic                i_out_stall,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic [VTX_W-1:0]    o_visited_vertex,
    output logic                o_last_of_walk,
    output logic                o_bad_start
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int DW   = $clog2(MAX_VERTICES + 1);
    localparam int GRP  = 8;
    localparam int NGRP = (MAX_VERTICES + GRP - 1) / GRP;

    logic [VCOUNT_W-1:0]     r_vcount;
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic                    r_rvld;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [DW-1:0]           r_depth;
    logic [VW-1:0]           r_pend;
    logic [NGRP-1:0]         r_gany;
    logic [2:0]              r_gidx [NGRP];
    logic                    r_out_valid;
    logic [VW-1:0]           r_out_vtx;
    logic                    r_out_last;
    logic                    r_out_bad;

    logic [NGRP-1:0]         n_gany;
    logic [2:0]              n_gidx [NGRP];

    logic [VCOUNT_W-1:0]     cnt;
    logic                    bad_start;
    logic [VW-1:0]           row_v;
    logic [VW-1:0]           col_v;
    logic [VW-1:0]           start_v;
    logic                    load_ok;
    logic                    is_edge;
    logic [MAX_VERTICES-1:0] col_bit;
    logic [MAX_VERTICES-1:0] start_bit;
    logic [MAX_VERTICES-1:0] adj_wmask;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic [MAX_VERTICES-1:0] row_bits;
    logic [MAX_VERTICES-1:0] lim;
    logic [MAX_VERTICES-1:0] cand;
    logic [NGRP*GRP-1:0]     pad;
    logic                    found;
    logic [VW-1:0]           w_sel;
    logic                    stk_we;
    logic [VW-1:0]           stk_waddr;
    logic [VW-1:0]           stk_wdata;
    logic [VW-1:0]           stk_raddr;
    logic [VW-1:0]           stk_rdata;
    logic                    out_free;
    logic                    emit;

    // Effective vertex count saturates at the maximum.
    assign cnt = (r_vcount > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES) : r_vcount;
    assign bad_start = (VCOUNT_W'(i_start_vertex) >= cnt);

    assign row_v   = i_row_vertex[VW-1:0];
    assign col_v   = i_col_vertex[VW-1:0];
    assign start_v = i_start_vertex[VW-1:0];

    assign load_ok = i_cmd.load
                  && (VCOUNT_W'(i_row_vertex) < VCOUNT_W'(MAX_VERTICES))
                  && (VCOUNT_W'(i_col_vertex) < VCOUNT_W'(MAX_VERTICES));
    assign is_edge = (i_edge_weight != '0) && (i_edge_weight != NO_EDGE_MARK);

    always_comb begin
        col_bit          = '0;
        col_bit[col_v]   = 1'b1;
        start_bit        = '0;
        start_bit[start_v] = 1'b1;
    end

    // A row never written reads as zero; its first write stores the whole row.
    assign adj_wmask = r_row_vld[row_v] ? col_bit : '1;
    assign adj_wdata = is_edge ? col_bit : '0;

    gdp_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (row_v),
        .i_wdata (adj_wdata),
        .i_wmask (adj_wmask),
        .i_raddr (stk_rdata),
        .o_rdata (adj_rdata)
    );

    assign stk_we    = i_cmd.start_walk || i_cmd.push;
    assign stk_waddr = i_cmd.start_walk ? '0 : VW'(r_depth);
    assign stk_wdata = i_cmd.start_walk ? start_v : w_sel;
    assign stk_raddr = VW'(r_depth - DW'(1));

    gdp_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_wmask ('1),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign row_bits = adj_rdata & {MAX_VERTICES{r_rvld}};

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            lim[i] = (VCOUNT_W'(i) < cnt);
        end
    end

    assign cand = row_bits & lim & ~r_visited;

    // First search stage: lowest set bit within each group of eight.
    always_comb begin
        pad                   = '0;
        pad[MAX_VERTICES-1:0] = cand;
        for (int g = 0; g < NGRP; g++) begin
            n_gany[g] = |pad[g*GRP +: GRP];
            n_gidx[g] = 3'd0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (pad[g*GRP + b]) begin
                    n_gidx[g] = 3'(b);
                end
            end
        end
    end

    // Second search stage: lowest group holding a candidate.
    always_comb begin
        found = |r_gany;
        w_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_gany[g]) begin
                w_sel = VW'(g * GRP + int'(r_gidx[g]));
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = i_cmd.push || i_cmd.flush || i_cmd.emit_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= VCOUNT_RESET;
            r_row_vld   <= '0;
            r_visited   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (load_ok) begin
                r_row_vld[row_v] <= 1'b1;
            end
            if (i_cmd.clear_visited) begin
                r_visited <= '0;
                r_depth   <= '0;
            end else if (i_cmd.start_walk) begin
                r_visited <= start_bit;
                r_depth   <= DW'(1);
            end else if (i_cmd.push) begin
                r_visited[w_sel] <= 1'b1;
                r_depth          <= r_depth + DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= r_depth - DW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld <= r_row_vld[stk_rdata];
        r_gany <= n_gany;
        for (int g = 0; g < NGRP; g++) begin
            r_gidx[g] <= n_gidx[g];
        end
        if (i_cmd.start_walk) begin
            r_pend <= start_v;
        end else if (i_cmd.push) begin
            r_pend <= w_sel;
        end
        if (i_cmd.emit_bad) begin
            r_out_vtx  <= '0;
            r_out_last <= 1'b1;
            r_out_bad  <= 1'b1;
        end else if (i_cmd.flush || i_cmd.push) begin
            r_out_vtx  <= r_pend;
            r_out_last <= i_cmd.flush;
            r_out_bad  <= 1'b0;
        end
    end

    assign o_status.found        = found;
    assign o_status.depth_is_one = (r_depth == DW'(1));
    assign o_status.out_free     = out_free;
    assign o_status.bad_start    = bad_start;

    assign o_out_valid      = r_out_valid;
    assign o_visited_vertex = VTX_W'(r_out_vtx);
    assign o_last_of_walk   = r_out_last;
    assign o_bad_start      = r_out_bad;

    `GDP_ASSERT_NOW(a_emit_room, emit, out_free, "result overwrote an untaken item")
    `GDP_ASSERT_NOW(a_depth_bound, 1'b1, r_depth <= DW'(MAX_VERTICES), "stack depth above maximum")
    `GDP_ASSERT_NEXT(a_run_visited, i_cmd.clear_visited || i_cmd.start_walk, $onehot0(r_visited), "visited set not reset by run")
    `GDP_ASSERT_NOW(a_out_source, $rose(r_out_valid), $past(emit), "output valid rose without a result")

endmodule

>>> rtl/graph_dfs_preorder_top.sv
// Top level of the depth-first preorder walk over an adjacency bit matrix.
// Depends on gdp_pkg, gdp_ctrl and gdp_datapath (which uses gdp_ram).
//
//  Channel  | Valid        | Stall        | Payload
//  ---------+--------------+--------------+-------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_operation, i_row_vertex, i_col_vertex,
//           |              |              | i_edge_weight, i_start_vertex
//  output   | o_out_valid  | i_out_stall  | o_visited_vertex, o_last_of_walk, o_bad_start
//  config   | i_cfg_we     | (none)       | i_cfg_data (vertex count)
//
// Matrix loads are accepted while idle and stream at one item per cycle.
// A run is accepted, then each walk step passes through the stack read, adjacency
// row read, group search and pick states; a walk reaching n vertices makes 2n-1 steps
// plus a final flush, and a bad start goes to its own state for the result hand-off.
// The serial stack and adjacency memory reads set the step length; input stays stalled
// for the whole run. Output stalls hold the walk in a pushing pick, flush or bad start.
// Reset is synchronous and active low; no clearing pass is needed, since per-row valid
// flops make unwritten adjacency rows read as zero.

module graph_dfs_preorder_top import gdp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [VCOUNT_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [VTX_W-1:0]    i_row_vertex,
    input  logic [VTX_W-1:0]    i_col_vertex,
    input  logic [WEIGHT_W-1:0] i_edge_weight,
    input  logic [VTX_W-1:0]    i_start_vertex,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [VTX_W-1:0]    o_visited_vertex,
    output logic                o_last_of_walk,
    output logic                o_bad_start
);

    // Commands flow from the controller into the datapath; status flows back.
    t_cmd    cmd;
    t_status status;

    // The controller owns the input handshake and sequences each walk step.
    gdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    // The datapath holds the graph, the stack, the visited set and the output register.
    // Each visited vertex is held pending until the next push or the flush, so the last can carry the end-of-walk flag.
    gdp_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_row_vertex     (i_row_vertex),
        .i_col_vertex     (i_col_vertex),
        .i_edge_weight    (i_edge_weight),
        .i_start_vertex   (i_start_vertex),
        .i_cmd            (cmd),
        .i_out_stall      (i_out_stall),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_visited_vertex (o_visited_vertex),
        .o_last_of_walk   (o_last_of_walk),
        .o_bad_start      (o_bad_start)
    );

endmodule
